// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL core.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bud_pkg.sv =====
// Types and constants for the button up/down counter display.
// No dependencies; imported by button_updown_counter_display.
`timescale 1ns / 1ps

package bud_pkg;

    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int COUNT_W = 10;
    localparam int BCD_W   = 4;
    localparam int SEG_W   = 7;
    localparam int SEL_W   = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [BCD_W-1:0]     bcd_t;

    localparam cfg_idx_t REG_SCAN_INTERVAL     = 2'd0;
    localparam cfg_idx_t REG_DEBOUNCE_INTERVAL = 2'd1;
    localparam cfg_idx_t REG_REFRESH_PERIOD    = 2'd2;

    localparam logic [CFG_W-1:0] SCAN_RESET     = 8'd10;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 8'd20;
    localparam logic [CFG_W-1:0] REFRESH_RESET  = 8'd5;

    localparam logic [COUNT_W-1:0] COUNT_MIN = 10'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd999;

    localparam logic [1:0] POS_HUNDREDS = 2'd0;
    localparam logic [1:0] POS_TENS     = 2'd1;
    localparam logic [1:0] POS_UNITS    = 2'd2;

    localparam bcd_t BCD_ZERO = 4'd0;
    localparam bcd_t BCD_NINE = 4'd9;

    function automatic logic [SEG_W-1:0] seg_decode(input bcd_t d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'b0111111;
            4'd1:    s = 7'b0000110;
            4'd2:    s = 7'b1011011;
            4'd3:    s = 7'b1001111;
            4'd4:    s = 7'b1100110;
            4'd5:    s = 7'b1101101;
            4'd6:    s = 7'b1111101;
            4'd7:    s = 7'b0000111;
            4'd8:    s = 7'b1111111;
            4'd9:    s = 7'b1101111;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/button_updown_counter_display.sv =====
// Debounced up/down counter with a three-digit multiplexed 7-segment display.
// Depends on bud_pkg and assert_macros.svh.
// Each word is one tick with the two button levels; every tick yields one result
// word. The result word is registered: a tick passes the input register, then the
// state/result registers. One tick is accepted per cycle while out_stall does not
// hold the result; the debounce sequencer, the decimal digit registers and the
// refresh counter are updated once per accepted tick. The count is held both in
// binary and as three decimal digits, so no division is needed for the display.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module button_updown_counter_display
    import bud_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 plus_level,
    input  logic                 minus_level,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SEG_W-1:0]     segments,
    output logic [SEL_W-1:0]     digit_select,
    output logic [COUNT_W-1:0]   count_value
);

    typedef enum logic [1:0] {
        WAIT_PRESS,
        DEB_PRESS,
        WAIT_REL,
        DEB_REL
    } phase_t;

    logic [CFG_W-1:0]   scan_interval_reg, debounce_interval_reg, refresh_period_reg;
    logic               in_full_reg, plus_q_reg, minus_q_reg;
    logic               out_valid_reg;
    phase_t             phase_reg, phase_next;
    logic [CFG_W-1:0]   wait_ticks_reg, wait_ticks_next;
    logic               plus_held_reg, plus_held_next;
    logic               minus_held_reg, minus_held_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    bcd_t               hund_reg, hund_next, tens_reg, tens_next, units_reg, units_next;
    logic [1:0]         scan_position_reg, scan_position_next;
    logic [CFG_W-1:0]   refresh_ticks_reg, refresh_ticks_next;
    logic [SEG_W-1:0]   segment_reg, segment_next;
    logic [SEL_W-1:0]   select_reg, select_next;

    logic               advance, take;
    logic [CFG_W-1:0]   limit;
    logic [CFG_W:0]     wait_elapsed, refresh_elapsed;
    logic               btn_fire, any_btn, do_inc, do_dec;
    logic [1:0]         pos;
    bcd_t               digit;
    logic               blank;

    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign take     = in_valid && !in_stall;
    assign in_stall = in_full_reg && !advance;

    always_comb
    begin
        limit = (phase_reg == DEB_PRESS || phase_reg == DEB_REL) ?
                debounce_interval_reg : scan_interval_reg;
        wait_elapsed = {1'b0, wait_ticks_reg} + 9'd1;
        btn_fire     = !(wait_elapsed < {1'b0, limit});
        any_btn      = plus_q_reg || minus_q_reg;

        phase_next      = phase_reg;
        wait_ticks_next = btn_fire ? '0 : wait_elapsed[CFG_W-1:0];
        plus_held_next  = plus_held_reg;
        minus_held_next = minus_held_reg;
        do_inc          = 1'b0;
        do_dec          = 1'b0;

        if (btn_fire)
        begin
            case (phase_reg)
                WAIT_PRESS:
                begin
                    if (any_btn)
                        phase_next = DEB_PRESS;
                end
                DEB_PRESS:
                begin
                    plus_held_next  = plus_q_reg;
                    minus_held_next = minus_q_reg;
                    phase_next      = any_btn ? WAIT_REL : WAIT_PRESS;
                    do_inc = plus_q_reg && !minus_q_reg && (count_reg != COUNT_MAX);
                    do_dec = minus_q_reg && !plus_q_reg && (count_reg != COUNT_MIN);
                end
                WAIT_REL:
                begin
                    if (!any_btn)
                        phase_next = DEB_REL;
                end
                DEB_REL:
                begin
                    plus_held_next  = plus_q_reg;
                    minus_held_next = minus_q_reg;
                    phase_next      = any_btn ? WAIT_REL : WAIT_PRESS;
                end
                default:
                    phase_next = WAIT_PRESS;
            endcase
        end

        count_next = count_reg;
        hund_next  = hund_reg;
        tens_next  = tens_reg;
        units_next = units_reg;
        if (do_inc)
        begin
            count_next = count_reg + 10'd1;
            if (units_reg == BCD_NINE)
            begin
                units_next = BCD_ZERO;
                if (tens_reg == BCD_NINE)
                begin
                    tens_next = BCD_ZERO;
                    hund_next = hund_reg + 4'd1;
                end
                else
                    tens_next = tens_reg + 4'd1;
            end
            else
                units_next = units_reg + 4'd1;
        end
        else if (do_dec)
        begin
            count_next = count_reg - 10'd1;
            if (units_reg == BCD_ZERO)
            begin
                units_next = BCD_NINE;
                if (tens_reg == BCD_ZERO)
                begin
                    tens_next = BCD_NINE;
                    hund_next = hund_reg - 4'd1;
                end
                else
                    tens_next = tens_reg - 4'd1;
            end
            else
                units_next = units_reg - 4'd1;
        end

        // display refresh uses this tick's updated count
        refresh_elapsed    = {1'b0, refresh_ticks_reg} + 9'd1;
        refresh_ticks_next = refresh_elapsed[CFG_W-1:0];
        scan_position_next = scan_position_reg;
        segment_next       = segment_reg;
        select_next        = select_reg;
        pos   = (scan_position_reg > POS_UNITS) ? POS_HUNDREDS : scan_position_reg;
        digit = units_next;
        blank = 1'b0;
        case (pos)
            POS_HUNDREDS:
            begin
                digit = hund_next;
                blank = (hund_next == BCD_ZERO);
            end
            POS_TENS:
            begin
                digit = tens_next;
                blank = (hund_next == BCD_ZERO) && (tens_next == BCD_ZERO);
            end
            default:
            begin
                digit = units_next;
                blank = 1'b0;
            end
        endcase
        if (!(refresh_elapsed < {1'b0, refresh_period_reg}))
        begin
            refresh_ticks_next = '0;
            scan_position_next = (pos == POS_UNITS) ? POS_HUNDREDS : pos + 2'd1;
            if (blank)
            begin
                segment_next = '0;
                select_next  = '0;
            end
            else
            begin
                segment_next = seg_decode(digit);
                case (pos)
                    POS_HUNDREDS: select_next = 3'b100;
                    POS_TENS:     select_next = 3'b010;
                    default:      select_next = 3'b001;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_interval_reg     <= SCAN_RESET;
            debounce_interval_reg <= DEBOUNCE_RESET;
            refresh_period_reg    <= REFRESH_RESET;
            in_full_reg           <= 1'b0;
            plus_q_reg            <= 1'b0;
            minus_q_reg           <= 1'b0;
            out_valid_reg         <= 1'b0;
            phase_reg             <= WAIT_PRESS;
            wait_ticks_reg        <= '0;
            plus_held_reg         <= 1'b0;
            minus_held_reg        <= 1'b0;
            count_reg             <= COUNT_MIN;
            hund_reg              <= BCD_ZERO;
            tens_reg              <= BCD_ZERO;
            units_reg             <= 4'd1;
            scan_position_reg     <= POS_HUNDREDS;
            refresh_ticks_reg     <= '0;
            segment_reg           <= '0;
            select_reg            <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SCAN_INTERVAL:     scan_interval_reg     <= cfg_data;
                    REG_DEBOUNCE_INTERVAL: debounce_interval_reg <= cfg_data;
                    REG_REFRESH_PERIOD:    refresh_period_reg    <= cfg_data;
                    default:               ;
                endcase
            end

            if (take)
            begin
                in_full_reg <= 1'b1;
                plus_q_reg  <= plus_level;
                minus_q_reg <= minus_level;
            end
            else if (advance)
                in_full_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                phase_reg         <= phase_next;
                wait_ticks_reg    <= wait_ticks_next;
                plus_held_reg     <= plus_held_next;
                minus_held_reg    <= minus_held_next;
                count_reg         <= count_next;
                hund_reg          <= hund_next;
                tens_reg          <= tens_next;
                units_reg         <= units_next;
                scan_position_reg <= scan_position_next;
                refresh_ticks_reg <= refresh_ticks_next;
                segment_reg       <= segment_next;
                select_reg        <= select_next;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign segments     = segment_reg;
    assign digit_select = select_reg;
    assign count_value  = count_reg;

    `ASSERT_ALWAYS(a_count_range, clk, rst_n,
        (count_reg >= COUNT_MIN) && (count_reg <= COUNT_MAX), "count out of range")
    `ASSERT_ALWAYS(a_bcd_match, clk, rst_n,
        ({6'd0, hund_reg} * 10'd100 + {6'd0, tens_reg} * 10'd10 + {6'd0, units_reg})
            == count_reg, "decimal digits disagree with count")
    `ASSERT_IMPLY(a_held_release, clk, rst_n,
        (phase_reg == WAIT_REL) || (phase_reg == DEB_REL),
        plus_held_reg || minus_held_reg, "release phase with no held button")
    `ASSERT_IMPLY(a_held_press, clk, rst_n,
        (phase_reg == WAIT_PRESS) || (phase_reg == DEB_PRESS),
        !plus_held_reg && !minus_held_reg, "press phase with a held button")
    `ASSERT_IMPLY(a_select_onehot, clk, rst_n, 1'b1,
        $onehot0(select_reg) && ((select_reg == '0) == (segment_reg == '0)),
        "digit enable and segments inconsistent")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for button_updown_counter_display: debounce, clamp and display scan.
// Depends on bud_pkg and the RTL top; drives ticks and checks each result word against a
// built-in predictor.
`timescale 1ns / 1ps

module testbench;
    import bud_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CAP     = 40;

    localparam logic [10*SEG_W-1:0] SEG_FONT = {
        7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    typedef enum logic [1:0] {
        WAIT_PRESS,
        CONFIRM_PRESS,
        WAIT_RELEASE,
        CONFIRM_RELEASE
    } press_phase_t;

    typedef struct packed {
        logic plus;
        logic minus;
    } button_word_t;

    typedef struct packed {
        logic [SEG_W-1:0]   seg;
        logic [SEL_W-1:0]   sel;
        logic [COUNT_W-1:0] count;
    } display_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SCAN_INTERVAL;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 plus_level = 1'b0;
    logic                 minus_level = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [SEG_W-1:0]     segments;
    logic [SEL_W-1:0]     digit_select;
    logic [COUNT_W-1:0]   count_value;

    // predictor state and configuration copy
    logic [CFG_W-1:0]   scan_ticks = SCAN_RESET;
    logic [CFG_W-1:0]   debounce_ticks = DEBOUNCE_RESET;
    logic [CFG_W-1:0]   refresh_len = REFRESH_RESET;
    press_phase_t       press_phase = WAIT_PRESS;
    logic [7:0]         wait_cnt = '0;
    logic [COUNT_W-1:0] count_model = COUNT_MIN;
    logic [1:0]         scan_pos = POS_HUNDREDS;
    logic [7:0]         refresh_cnt = '0;
    logic [SEG_W-1:0]   seg_model = '0;
    logic [SEL_W-1:0]   sel_model = '0;

    button_word_t  tick_queue[$];
    display_word_t expected_display[$];
    int            ticks_queued = 0;
    int            mismatch_count = 0;
    int            send_gap = 0;
    int            stall_left = 0;
    int            quiet_cycles = 0;
    logic          idle_on = 1'b1;

    button_updown_counter_display dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .plus_level   (plus_level),
        .minus_level  (minus_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .segments     (segments),
        .digit_select (digit_select),
        .count_value  (count_value)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic advance_tick(input logic p, input logic m);
        logic [CFG_W-1:0] limit;
        logic [8:0]       elapsed;
        logic [1:0]       pos;
        int               hundreds;
        int               tens;
        int               units;
        int               digit;
        logic             blank;
        limit = (press_phase == CONFIRM_PRESS || press_phase == CONFIRM_RELEASE) ?
                debounce_ticks : scan_ticks;
        elapsed = {1'b0, wait_cnt} + 9'd1;
        if (elapsed < {1'b0, limit})
        begin
            wait_cnt = elapsed[7:0];
        end
        else
        begin
            wait_cnt = '0;
            case (press_phase)
                WAIT_PRESS:
                begin
                    if (p || m)
                        press_phase = CONFIRM_PRESS;
                end
                CONFIRM_PRESS:
                begin
                    if (p || m)
                    begin
                        if (p && !m && count_model < COUNT_MAX)
                            count_model = count_model + 1'b1;
                        else if (m && !p && count_model > COUNT_MIN)
                            count_model = count_model - 1'b1;
                        press_phase = WAIT_RELEASE;
                    end
                    else
                    begin
                        press_phase = WAIT_PRESS;
                    end
                end
                WAIT_RELEASE:
                begin
                    if (!p && !m)
                        press_phase = CONFIRM_RELEASE;
                end
                default:
                begin
                    press_phase = (p || m) ? WAIT_RELEASE : WAIT_PRESS;
                end
            endcase
        end

        elapsed = {1'b0, refresh_cnt} + 9'd1;
        if (elapsed < {1'b0, refresh_len})
        begin
            refresh_cnt = elapsed[7:0];
        end
        else
        begin
            refresh_cnt = '0;
            pos = (scan_pos > POS_UNITS) ? POS_HUNDREDS : scan_pos;
            hundreds = count_model / 100;
            tens = (count_model / 10) % 10;
            units = count_model % 10;
            case (pos)
                POS_HUNDREDS:
                begin
                    digit = hundreds;
                    blank = (hundreds == 0);
                end
                POS_TENS:
                begin
                    digit = tens;
                    blank = (hundreds == 0) && (tens == 0);
                end
                default:
                begin
                    digit = units;
                    blank = 1'b0;
                end
            endcase
            if (blank)
            begin
                seg_model = '0;
                sel_model = '0;
            end
            else
            begin
                seg_model = SEG_FONT[digit*SEG_W +: SEG_W];
                sel_model = 3'b001 << (POS_UNITS - pos);
            end
            scan_pos = (pos >= POS_UNITS) ? POS_HUNDREDS : pos + 2'd1;
        end
        expected_display.push_back('{seg_model, sel_model, count_model});
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        logic         busy;
        button_word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            plus_level <= 1'b0;
            minus_level <= 1'b0;
        end
        else
        begin
            busy = in_valid;
            if (in_valid && !in_stall)
            begin
                advance_tick(plus_level, minus_level);
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() > 0)
                begin
                    w = tick_queue.pop_front();
                    in_valid <= 1'b1;
                    plus_level <= w.plus;
                    minus_level <= w.minus;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 9);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        display_word_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_display.size() == 0)
                begin
                    $error("result word with no expectation pending");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_display.pop_front();
                    if (segments !== want.seg)
                    begin
                        $error("segments: expected %02h, got %02h", want.seg, segments);
                        mismatch_count++;
                    end
                    if (digit_select !== want.sel)
                    begin
                        $error("digit_select: expected %0b, got %0b", want.sel, digit_select);
                        mismatch_count++;
                    end
                    if (count_value !== want.count)
                    begin
                        $error("count_value: expected %0d, got %0d", want.count, count_value);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_ticks(input logic p, input logic m, input int n);
        repeat (n)
        begin
            tick_queue.push_back('{p, m});
            ticks_queued++;
        end
    endtask

    task automatic press_button(input logic p, input logic m);
        push_ticks(p, m, 2);
        push_ticks(1'b0, 1'b0, 2);
    endtask

    task automatic climb_count(input int presses);
        repeat (presses)
            press_button(1'b1, 1'b0);
    endtask

    // mostly complete press/release sequences, some bounce and noise
    task automatic random_presses(input int total);
        int   start;
        int   span;
        int   r;
        logic p;
        logic m;
        start = ticks_queued;
        span = scan_ticks + debounce_ticks + 2;
        if (span > HOLD_CAP)
            span = HOLD_CAP;
        while (ticks_queued - start < total)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
            begin
                r = $urandom_range(0, 9);
                p = (r < 5) || (r == 9);
                m = (r >= 5);
                if ($urandom_range(0, 3) == 0)
                    push_ticks(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               $urandom_range(1, 3));
                if ($urandom_range(0, 3) == 0)
                    push_ticks(p, m, $urandom_range(1, span));
                else
                    push_ticks(p, m, $urandom_range(span / 2, span));
                push_ticks(1'b0, 1'b0, $urandom_range(span / 2, span));
            end
            else if (r < 9)
            begin
                repeat ($urandom_range(1, 5))
                    push_ticks(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
            end
            else
            begin
                push_ticks(1'b0, 1'b0, $urandom_range(1, span));
            end
        end
    endtask

    task automatic drain();
        while (tick_queue.size() != 0 || in_valid || expected_display.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_register(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SCAN_INTERVAL:     scan_ticks = value;
            REG_DEBOUNCE_INTERVAL: debounce_ticks = value;
            default:               refresh_len = value;
        endcase
    endtask

    task automatic configure(input logic [CFG_W-1:0] scan, input logic [CFG_W-1:0] deb,
                             input logic [CFG_W-1:0] refresh);
        set_register(REG_SCAN_INTERVAL, scan);
        set_register(REG_DEBOUNCE_INTERVAL, deb);
        set_register(REG_REFRESH_PERIOD, refresh);
        @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset intervals
        idle_on = 1'b1;
        random_presses(30);
        drain();

        // directed: clamp at the bottom, both buttons, press lost in debounce,
        // button pressed again during release debounce
        configure(8'd1, 8'd1, 8'd1);
        press_button(1'b0, 1'b1);
        press_button(1'b1, 1'b0);
        press_button(1'b1, 1'b1);
        push_ticks(1'b0, 1'b1, 1);
        push_ticks(1'b0, 1'b0, 2);
        push_ticks(1'b1, 1'b0, 2);
        push_ticks(1'b0, 1'b0, 1);
        push_ticks(1'b1, 1'b0, 1);
        push_ticks(1'b0, 1'b0, 2);
        press_button(1'b1, 1'b0);
        drain();

        configure(8'd2, 8'd3, 8'd255);
        random_presses(30);
        drain();

        // long wait, then the scan interval drops below the elapsed count
        idle_on = 1'b0;
        configure(8'd200, 8'd200, 8'd7);
        push_ticks(1'b0, 1'b0, 20);
        drain();
        configure(8'd3, 8'd0, 8'd0);
        random_presses(30);
        drain();

        idle_on = 1'b1;
        configure(8'd255, 8'd255, 8'd255);
        random_presses(30);
        drain();

        configure(8'd4, 8'd6, 8'd3);
        random_presses(30);
        drain();

        // climb past one hundred so the hundreds digit is shown
        configure(8'd1, 8'd1, 8'd1);
        climb_count(50);
        drain();
        idle_on = 1'b0;
        climb_count(50);
        press_button(1'b0, 1'b1);
        random_presses(20);
        drain();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
